>>> src/rsw_pkg.sv
// Shared types and codes for the response string watcher.
// Used by rsw_cell and response_string_watcher_top; depends on nothing.
package rsw_pkg;

   localparam int PATTERN_SLOTS = 16;
   localparam int LEN_W         = 5;
   localparam int IDLE_W        = 28;
   localparam int CSR_W         = 64;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [1:0] REG_LENGTH       = 2'd2;
   localparam logic [1:0] REG_IDLE_LIMIT   = 2'd3;

   localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_MATCHED = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef logic [PATTERN_SLOTS-1:0][7:0] pattern_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

>>> src/rsw_cell.sv
// One position of the compare window: holds a byte, passes it to the next cell.
// Depends on rsw_pkg for the pattern and control types.
module rsw_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  rsw_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]            byte_in,
   input  rsw_pkg::pattern_type  pattern,
   input  logic [rsw_pkg::LEN_W-1:0] length,
   output logic [7:0]            byte_out,
   output logic                  match_out
);
   import rsw_pkg::*;

   localparam logic [LEN_W-1:0] POS = LEN_W'(IDX);

   logic [7:0]       byte_ff;
   logic [7:0]       byte_in_d;
   logic             active;
   logic [LEN_W-1:0] diff;
   logic [3:0]       sel;

   // The compare looks at the byte this cell will hold after the shift.
   assign active    = length > POS;
   assign diff      = length - LEN_W'(1) - POS;
   assign sel       = diff[3:0];
   assign match_out = !active || (byte_in == pattern[sel]);
   assign byte_out  = byte_ff;

   always_comb begin
      byte_in_d = byte_ff;
      if (ctrl.clear) begin
         byte_in_d = 8'd0;
      end else if (ctrl.shift) begin
         byte_in_d = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_d;
   end

endmodule

>>> src/response_string_watcher_top.sv
// Top level of the response string watcher: control, counters and the cell chain.
// Depends on rsw_pkg and rsw_cell.
//
// Usage: each request transfer carries a command (start, received byte or idle
// tick) and a byte. Every request gives exactly one response transfer with the
// current status (pending, matched, timed out) and the number of stored bytes.
// A start clears the watch. Bytes shift through a chain of MAX_PATTERN cells,
// each comparing its next byte with its pattern byte, and the matched flags are
// combined in the same cycle. A taken request is answered in the next cycle, and
// one request is taken every cycle while the response side keeps up. When the
// receiver stalls, the response register holds and req_ready falls until it is
// taken. Synchronous reset restores the default registers (pattern "OK",
// length 2, idle limit 16000000) and a cleared, pending watch; there is no
// clearing pass. Register writes on the csr_ port apply to the next request.
module response_string_watcher_top #(
   parameter int MAX_PATTERN  = 16,
   parameter int BUFFER_BYTES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_cmd,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [7:0]                  rsp_bytes_stored,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [rsw_pkg::CSR_W-1:0]   csr_wdata
);
   import rsw_pkg::*;

   localparam int CNT_W   = $clog2(BUFFER_BYTES);
   localparam int LEN_LIM = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;
   localparam logic [CNT_W-1:0] STORE_LIM = CNT_W'(BUFFER_BYTES - 1);

   logic [63:0]       pat_low_ff, pat_high_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   logic [IDLE_W-1:0] idle_limit_ff;

   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;
   status_type        status_ff, status_in;
   logic              zero_ff, zero_in;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [7:0]        rsp_count_ff;

   logic              req_fire;
   logic              store_byte;
   logic [CNT_W-1:0]  stored_inc;
   logic [IDLE_W-1:0] idle_inc;
   logic [LEN_W-1:0]  eff_len;
   pattern_type       pattern;
   cell_ctrl_type     ctrl;
   logic              window_match;

   logic [MAX_PATTERN-1:0][7:0] cell_byte;
   logic [MAX_PATTERN-1:0]      cell_match;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign pattern = {pat_high_ff, pat_low_ff};

   always_comb begin
      eff_len = (pat_len_ff == '0) ? LEN_W'(1) : pat_len_ff;
      if (eff_len > LEN_W'(LEN_LIM)) begin
         eff_len = LEN_W'(LEN_LIM);
      end
   end

   assign store_byte = req_fire && (req_cmd == CMD_BYTE) && (status_ff == ST_PENDING)
                       && (stored_ff < STORE_LIM);
   assign ctrl.shift = store_byte;
   assign ctrl.clear = req_fire && (req_cmd == CMD_START);

   genvar g;
   generate
      for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
         rsw_cell #(.IDX(g)) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .byte_in   ((g == 0) ? req_rx_byte : cell_byte[(g == 0) ? 0 : g - 1]),
            .pattern   (pattern),
            .length    (eff_len),
            .byte_out  (cell_byte[g]),
            .match_out (cell_match[g])
         );
      end
   endgenerate

   assign stored_inc   = stored_ff + CNT_W'(1);
   assign idle_inc     = (idle_ff < IDLE_MAX) ? idle_ff + IDLE_W'(1) : idle_ff;
   assign window_match = (&cell_match) && !(zero_ff || (req_rx_byte == 8'd0))
                         && (32'(stored_inc) >= 32'(eff_len));

   always_comb begin
      stored_in = stored_ff;
      idle_in   = idle_ff;
      status_in = status_ff;
      zero_in   = zero_ff;
      if (req_fire) begin
         case (req_cmd)
            CMD_START: begin
               stored_in = '0;
               idle_in   = '0;
               status_in = ST_PENDING;
               zero_in   = 1'b0;
            end
            CMD_BYTE: begin
               if (status_ff == ST_PENDING) begin
                  idle_in = '0;
                  if (store_byte) begin
                     stored_in = stored_inc;
                     zero_in   = zero_ff || (req_rx_byte == 8'd0);
                     if (window_match) begin
                        status_in = ST_MATCHED;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (status_ff == ST_PENDING) begin
                  idle_in = idle_inc;
                  if (idle_inc >= idle_limit_ff) begin
                     status_in = ST_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff    <= 64'd19279;
         pat_high_ff   <= 64'd0;
         pat_len_ff    <= LEN_W'(2);
         idle_limit_ff <= IDLE_W'(16000000);
      end else if (csr_we) begin
         case (csr_index)
            REG_PATTERN_LOW:  pat_low_ff    <= csr_wdata;
            REG_PATTERN_HIGH: pat_high_ff   <= csr_wdata;
            REG_LENGTH:       pat_len_ff    <= csr_wdata[LEN_W-1:0];
            REG_IDLE_LIMIT:   idle_limit_ff <= csr_wdata[IDLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff    <= '0;
         idle_ff      <= '0;
         status_ff    <= ST_PENDING;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stored_ff <= stored_in;
         idle_ff   <= idle_in;
         status_ff <= status_in;
         zero_ff   <= zero_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= (32'(stored_in) > 32'd255) ? 8'hFF : 8'(stored_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bytes_stored = rsp_count_ff;

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_START)
      |=> (rsp_status == ST_PENDING) && (rsp_bytes_stored == 8'd0))
      else $error("start transfer did not clear the watch");

   a_sticky: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd != CMD_START) && (status_ff != ST_PENDING)
      |=> (rsp_status == $past(status_ff)) && (stored_ff == $past(stored_ff)))
      else $error("final status changed without a start");

   a_zero_blocks: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_BYTE) && zero_ff && (status_ff == ST_PENDING)
      |=> rsp_status != ST_MATCHED)
      else $error("match reported after a stored zero byte");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= STORE_LIM)
      else $error("stored byte count exceeds the buffer");

endmodule
